### rtl/core/ofd_pkg.sv
// Package: shared types and constants of the oximeter frame deframer.
`default_nettype none

package ofd_pkg;

   localparam logic [7:0] HDR_FIRST     = 8'hAA;
   localparam logic [7:0] HDR_SECOND    = 8'h55;
   localparam logic [7:0] MEAS_CODE     = 8'd21;
   localparam logic [7:0] MEAS_MIN_LEN  = 8'd10;
   localparam logic [7:0] BYTE_INVALID  = 8'd127;
   localparam logic [15:0] PULSE_INVALID = 16'd255;

   // payload positions that are captured
   localparam logic [7:0] POS_CODE     = 8'd0;
   localparam logic [7:0] POS_WAVE     = 8'd2;
   localparam logic [7:0] POS_SPO2     = 8'd4;
   localparam logic [7:0] POS_PULSE_HI = 8'd5;
   localparam logic [7:0] POS_PULSE_LO = 8'd6;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      PH_HUNT_A = 3'd0,
      PH_HUNT_B = 3'd1,
      PH_LEN    = 3'd2,
      PH_BODY   = 3'd3,
      PH_CHK    = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_MEAS     = 2'd0,
      ST_CHK_ERR  = 2'd1,
      ST_IGNORED  = 2'd2
   } status_type;

   // one completed frame, as handed from the parser to the result stage
   typedef struct packed {
      status_type  status;
      logic [7:0]  code;
      logic [7:0]  wave;
      logic [7:0]  spo2;
      logic [15:0] pulse;
   } frame_rec_type;

   // queue read side towards the result stage
   typedef struct packed {
      logic          valid;
      frame_rec_type rec;
   } rec_chan_type;

endpackage

`default_nettype wire

### rtl/core/ofd_if.sv
// Interfaces: byte input channel and frame result channel.
`default_nettype none

interface ofd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ofd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_status;
   logic [7:0]  frame_code;
   logic        wave_valid;
   logic [7:0]  wave_value;
   logic        spo2_valid;
   logic [7:0]  spo2_value;
   logic        pulse_valid;
   logic [15:0] pulse_rate;

   modport source (output valid, output frame_status, output frame_code,
                   output wave_valid, output wave_value, output spo2_valid,
                   output spo2_value, output pulse_valid, output pulse_rate,
                   input ready);
   modport sink   (input valid, input frame_status, input frame_code,
                   input wave_valid, input wave_value, input spo2_valid,
                   input spo2_value, input pulse_valid, input pulse_rate,
                   output ready);
endinterface

`default_nettype wire

### rtl/core/oximeter_frame_deframer_top.sv
// Oximeter frame deframer: AA 55 length-framed packets with additive checksum.
//
// req_chan carries one received byte per transfer (rx_byte). rsp_chan carries
// one result per completed frame of nonzero length: status, packet code and,
// for measurement frames, the smoothed waveform, SpO2 and pulse rate with
// their validity flags. Header bytes, length, payload and zero-length frames
// produce no result.
// Throughput: one byte per cycle. The parser takes a byte every cycle while
// the frame queue has room; the result stage drains one frame per cycle while
// its output register is empty or rsp_chan takes the held result. A frame's
// record is written into the queue as its checksum byte transfers, then moves
// into the output register, from which it is presented on rsp_chan.
// When the receiver stalls, results wait in the output register and the
// queue (QUEUE_DEPTH entries); once the queue is full req_chan.ready drops
// until rsp_chan transfers again.
// Reset (synchronous) restarts the header hunt, empties the queue and output
// register and clears the waveform smoothing state to zero.
`default_nettype none

module oximeter_frame_deframer_top #(
   parameter int QUEUE_DEPTH = ofd_pkg::QUEUE_DEPTH
) (
   input wire logic   clock,
   input wire logic   reset,
   ofd_req_if.sink    req_chan,
   ofd_rsp_if.source  rsp_chan
);
   import ofd_pkg::*;

   logic          q_push;
   logic          q_space;
   logic          q_pop;
   frame_rec_type q_rec;
   rec_chan_type  q_head;

   ofd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .req_space (q_space),
      .req_push  (q_push),
      .req_rec   (q_rec)
   );

   ofd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_rec (q_rec),
      .space    (q_space),
      .pop      (q_pop),
      .head     (q_head)
   );

   ofd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

### rtl/core/ofd_front.sv
// Front end: header hunt, length/payload/checksum parsing, frame classification.
`default_nettype none

module ofd_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   ofd_req_if.sink                     req_chan,
   input  wire logic                   req_space,
   output      logic                   req_push,
   output      ofd_pkg::frame_rec_type req_rec
);
   import ofd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  code_ff, code_in;
   logic [7:0]  wave_ff, wave_in;
   logic [7:0]  spo2_ff, spo2_in;
   logic [15:0] pulse_ff, pulse_in;

   logic       fire;
   logic [7:0] b;
   logic [7:0] cnt_next;

   assign req_chan.ready = req_space;
   assign fire     = req_chan.valid && req_chan.ready;
   assign b        = req_chan.rx_byte;
   assign cnt_next = cnt_ff + 8'd1;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         case (phase_ff)
            PH_HUNT_B: begin
               if (b == HDR_SECOND) phase_in = PH_LEN;
               else if (b != HDR_FIRST) phase_in = PH_HUNT_A;
            end
            PH_LEN:  phase_in = (b == 8'd0) ? PH_CHK : PH_BODY;
            PH_BODY: begin
               if (cnt_next == len_ff) phase_in = PH_CHK;
            end
            PH_CHK:  phase_in = PH_HUNT_A;
            default: phase_in = (b == HDR_FIRST) ? PH_HUNT_B : PH_HUNT_A;
         endcase
      end
   end

   // datapath and outputs
   always_comb begin
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      code_in  = code_ff;
      wave_in  = wave_ff;
      spo2_in  = spo2_ff;
      pulse_in = pulse_ff;
      req_push = 1'b0;

      req_rec.code  = code_ff;
      req_rec.wave  = wave_ff;
      req_rec.spo2  = spo2_ff;
      req_rec.pulse = pulse_ff;
      if (sum_ff != b)
         req_rec.status = ST_CHK_ERR;
      else if (code_ff != MEAS_CODE || len_ff < MEAS_MIN_LEN)
         req_rec.status = ST_IGNORED;
      else
         req_rec.status = ST_MEAS;

      if (fire) begin
         case (phase_ff)
            PH_LEN: begin
               len_in   = b;
               sum_in   = b;
               cnt_in   = 8'd0;
               code_in  = 8'd0;
               wave_in  = 8'd0;
               spo2_in  = 8'd0;
               pulse_in = 16'd0;
            end
            PH_BODY: begin
               sum_in = sum_ff + b;
               cnt_in = cnt_next;
               case (cnt_ff)
                  POS_CODE:     code_in = b;
                  POS_WAVE:     wave_in = b;
                  POS_SPO2:     spo2_in = b;
                  POS_PULSE_HI: pulse_in = {b, pulse_ff[7:0]};
                  POS_PULSE_LO: pulse_in = {pulse_ff[15:8], b};
                  default: ;
               endcase
            end
            PH_CHK: begin
               // zero-length frames are dropped
               req_push = (len_ff != 8'd0);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT_A;
         len_ff   <= 8'd0;
         cnt_ff   <= 8'd0;
         sum_ff   <= 8'd0;
         code_ff  <= 8'd0;
         wave_ff  <= 8'd0;
         spo2_ff  <= 8'd0;
         pulse_ff <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         code_ff  <= code_in;
         wave_ff  <= wave_in;
         spo2_ff  <= spo2_in;
         pulse_ff <= pulse_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/ofd_queue.sv
// Frame queue: small FIFO of classified frames between parser and result stage.
`default_nettype none

module ofd_queue #(
   parameter int DEPTH = ofd_pkg::QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire ofd_pkg::frame_rec_type push_rec,
   output      logic                   space,
   input  wire logic                   pop,
   output      ofd_pkg::rec_chan_type  head
);
   import ofd_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   frame_rec_type entry_ff [DEPTH];
   logic [IW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_pop;

   assign space      = (count_ff != FULL);
   assign head.valid = (count_ff != '0);
   assign head.rec   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + IW'(1);
      if (do_pop) rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + IW'(1);
      if (push && !do_pop) count_in = count_ff + CW'(1);
      else if (!push && do_pop) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/ofd_back.sv
// Back end: waveform smoothing, validity flags and the result output register.
`default_nettype none

module ofd_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ofd_pkg::rec_chan_type head,
   output      logic                  pop,
   ofd_rsp_if.source                  rsp_chan
);
   import ofd_pkg::*;

   logic        valid_ff, valid_in;
   logic [7:0]  smooth_ff, smooth_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  code_ff, code_in;
   logic        wave_v_ff, wave_v_in;
   logic [7:0]  wave_ff, wave_in;
   logic        spo2_v_ff, spo2_v_in;
   logic [7:0]  spo2_ff, spo2_in;
   logic        pulse_v_ff, pulse_v_in;
   logic [15:0] pulse_ff, pulse_in;
   logic [8:0]  avg_sum;
   logic        meas;

   // output register frees when empty or its transfer completes this cycle
   assign pop     = head.valid && (!valid_ff || rsp_chan.ready);
   assign avg_sum = {1'b0, smooth_ff} + {1'b0, head.rec.wave};
   assign meas    = (head.rec.status == ST_MEAS);

   always_comb begin
      valid_in   = valid_ff;
      smooth_in  = smooth_ff;
      status_in  = status_ff;
      code_in    = code_ff;
      wave_v_in  = wave_v_ff;
      wave_in    = wave_ff;
      spo2_v_in  = spo2_v_ff;
      spo2_in    = spo2_ff;
      pulse_v_in = pulse_v_ff;
      pulse_in   = pulse_ff;
      if (valid_ff && rsp_chan.ready) valid_in = 1'b0;
      if (pop) begin
         valid_in   = 1'b1;
         status_in  = head.rec.status;
         code_in    = head.rec.code;
         wave_v_in  = 1'b0;
         wave_in    = 8'd0;
         spo2_v_in  = 1'b0;
         spo2_in    = 8'd0;
         pulse_v_in = 1'b0;
         pulse_in   = 16'd0;
         if (meas) begin
            wave_v_in = (head.rec.wave != BYTE_INVALID);
            if (wave_v_in) smooth_in = avg_sum[8:1];
            wave_in    = smooth_in;
            spo2_v_in  = (head.rec.spo2 != BYTE_INVALID);
            spo2_in    = head.rec.spo2;
            pulse_v_in = (head.rec.pulse != PULSE_INVALID);
            pulse_in   = head.rec.pulse;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         smooth_ff <= 8'd0;
      end else begin
         valid_ff  <= valid_in;
         smooth_ff <= smooth_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      code_ff    <= code_in;
      wave_v_ff  <= wave_v_in;
      wave_ff    <= wave_in;
      spo2_v_ff  <= spo2_v_in;
      spo2_ff    <= spo2_in;
      pulse_v_ff <= pulse_v_in;
      pulse_ff   <= pulse_in;
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.frame_status = status_ff;
   assign rsp_chan.frame_code   = code_ff;
   assign rsp_chan.wave_valid   = wave_v_ff;
   assign rsp_chan.wave_value   = wave_ff;
   assign rsp_chan.spo2_valid   = spo2_v_ff;
   assign rsp_chan.spo2_value   = spo2_ff;
   assign rsp_chan.pulse_valid  = pulse_v_ff;
   assign rsp_chan.pulse_rate   = pulse_ff;

endmodule

`default_nettype wire
